// ----- sv/pointer_click_drag_classifier_defines.svh -----
// ----------------------------------------------------------------------------
// pointer click drag classifier assertion macros
// shared helpers for the port-level checker
// ----------------------------------------------------------------------------
`ifndef POINTER_CLICK_DRAG_CLASSIFIER_DEFINES_SVH
`define POINTER_CLICK_DRAG_CLASSIFIER_DEFINES_SVH

// same-cycle implication
`define PCD_ASSERT_NOW(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("pcd check failed");

// next-cycle implication
`define PCD_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("pcd check failed");

`endif

// ----- sv/pcd_pkg.sv -----
// ----------------------------------------------------------------------------
// pcd_pkg
// types and codes shared by the pointer click drag classifier
// ----------------------------------------------------------------------------
package pcd_pkg;

   localparam int COORD_W = 16;
   localparam int DELTA_W = 17;
   localparam int WORD_W  = 16;
   localparam int KIND_W  = 3;

   localparam logic [KIND_W-1:0] EV_MOVED    = 3'd0;
   localparam logic [KIND_W-1:0] EV_PRESSED  = 3'd1;
   localparam logic [KIND_W-1:0] EV_RELEASED = 3'd2;
   localparam logic [KIND_W-1:0] EV_CLICKED  = 3'd3;
   localparam logic [KIND_W-1:0] EV_DRAGGED  = 3'd4;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLICK_DISTANCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUTTON_MASK    = 2'd1;

   localparam logic [WORD_W-1:0] CLICK_DISTANCE_RESET = 16'd2;
   localparam logic [WORD_W-1:0] BUTTON_MASK_RESET    = 16'd31;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      JOB_MOVE,
      JOB_PRESS,
      JOB_RELEASE
   } job_kind_type;

   typedef struct packed {
      job_kind_type               kind;
      logic                       has_btn;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic signed [DELTA_W-1:0]  dx;
      logic signed [DELTA_W-1:0]  dy;
      logic [WORD_W-1:0]          now;
      logic [WORD_W-1:0]          diff;
      logic signed [COORD_W-1:0]  px;
      logic signed [COORD_W-1:0]  py;
      logic [WORD_W-1:0]          pb;
   } job_type;

endpackage

// ----- sv/pointer_click_drag_classifier.sv -----
// ----------------------------------------------------------------------------
// pointer_click_drag_classifier
// classifies pointer samples into move, press, release, click and drag items
//
//   channel  direction  payload
//   req_     in         tdata: pos_x, pos_y, buttons
//   rsp_     out        tdata: coord_a/b, word_a/b; tuser: event_kind; tlast
//   csr_     in         index 0 click_distance, 1 button_mask
//
// a sample enters per cycle while the two-entry job queue has room
// the back end output register emits one item per cycle: one for a move,
// press or buttonless release, two for a release of a tracked button
// reset is synchronous and clears position, button history and press store
// either side may stall; the queue and output register keep items apart
// ----------------------------------------------------------------------------
module pointer_click_drag_classifier
   import pcd_pkg::*;
#(
   parameter int NUM_BUTTONS = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [47:0]            req_tdata,   // pos_x, pos_y, buttons
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [103:0]           rsp_tdata,   // coord_a_x, coord_a_y, coord_b_x,
                                               // coord_b_y, word_a, word_b, zero pad
   output logic [KIND_W-1:0]      rsp_tuser,   // event_kind
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_data
);

   logic [WORD_W-1:0]         click_dist_ff, mask_ff;
   job_type                   front_job, head_job;
   logic                      q_full, q_empty, q_pop, accept;
   logic signed [COORD_W-1:0] ax, ay;
   logic signed [DELTA_W-1:0] bx, by;
   logic [WORD_W-1:0]         wa, wb;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         click_dist_ff <= CLICK_DISTANCE_RESET;
         mask_ff       <= BUTTON_MASK_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_CLICK_DISTANCE) begin
            click_dist_ff <= csr_data;
         end else if (csr_index == CSR_BUTTON_MASK) begin
            mask_ff <= csr_data;
         end
      end
   end

   pcd_front #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pos_x       (req_tdata[15:0]),
      .pos_y       (req_tdata[31:16]),
      .buttons     (req_tdata[47:32]),
      .button_mask (mask_ff),
      .job         (front_job)
   );

   pcd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .job_in  (front_job),
      .full    (q_full),
      .pop     (q_pop),
      .job_out (head_job),
      .empty   (q_empty)
   );

   pcd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job            (head_job),
      .empty          (q_empty),
      .pop            (q_pop),
      .click_distance (click_dist_ff),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_kind       (rsp_tuser),
      .rsp_ax         (ax),
      .rsp_ay         (ay),
      .rsp_bx         (bx),
      .rsp_by         (by),
      .rsp_wa         (wa),
      .rsp_wb         (wb),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tdata = {6'b0, wb, wa, by, bx, ay, ax};

endmodule

// ----- sv/pcd_queue.sv -----
// ----------------------------------------------------------------------------
// pcd_queue
// short job queue between the classifier front end and the result back end
// ----------------------------------------------------------------------------
module pcd_queue
   import pcd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type job_in,
   output logic    full,
   input  logic    pop,
   output job_type job_out,
   output logic    empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign job_out = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

// ----- sv/pcd_front.sv -----
// ----------------------------------------------------------------------------
// pcd_front
// accepts pointer samples, tracks position, buttons and press store,
// and classifies each sample into a job
// ----------------------------------------------------------------------------
module pcd_front
   import pcd_pkg::*;
#(
   parameter int NUM_BUTTONS = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic signed [COORD_W-1:0] pos_x,
   input  logic signed [COORD_W-1:0] pos_y,
   input  logic [WORD_W-1:0]         buttons,
   input  logic [WORD_W-1:0]         button_mask,
   output job_type                   job
);

   localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

   logic                      seen_ff;
   logic signed [COORD_W-1:0] cur_x_ff;
   logic signed [COORD_W-1:0] cur_y_ff;
   logic [WORD_W-1:0]         prev_ff;
   logic signed [COORD_W-1:0] press_x_ff [NUM_BUTTONS];
   logic signed [COORD_W-1:0] press_y_ff [NUM_BUTTONS];
   logic [WORD_W-1:0]         press_b_ff [NUM_BUTTONS];

   logic signed [COORD_W-1:0] old_x, old_y;
   logic [WORD_W-1:0]         prev_eff, diff, change;
   logic [IDX_W-1:0]          btn;
   logic                      has_btn;
   job_kind_type              kind;

   always_comb begin
      old_x    = seen_ff ? cur_x_ff : pos_x;
      old_y    = seen_ff ? cur_y_ff : pos_y;
      prev_eff = seen_ff ? prev_ff : '0;
      diff     = prev_eff ^ buttons;
      change   = diff & button_mask;
      has_btn  = |change[NUM_BUTTONS-1:0];
      btn      = '0;
      for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
         if (change[i]) begin
            btn = IDX_W'(i);
         end
      end
      priority if (change == '0) begin
         kind = JOB_MOVE;
      end else if ((buttons & change) != '0) begin
         kind = JOB_PRESS;
      end else begin
         kind = JOB_RELEASE;
      end
   end

   always_comb begin
      job.kind    = kind;
      job.has_btn = has_btn;
      job.x       = pos_x;
      job.y       = pos_y;
      job.dx      = {pos_x[COORD_W-1], pos_x} - {old_x[COORD_W-1], old_x};
      job.dy      = {pos_y[COORD_W-1], pos_y} - {old_y[COORD_W-1], old_y};
      job.now     = buttons;
      job.diff    = diff;
      job.px      = press_x_ff[btn];
      job.py      = press_y_ff[btn];
      job.pb      = press_b_ff[btn];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= 1'b0;
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         prev_ff  <= '0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            press_x_ff[i] <= '0;
            press_y_ff[i] <= '0;
            press_b_ff[i] <= '0;
         end
      end else if (accept) begin
         seen_ff  <= 1'b1;
         cur_x_ff <= pos_x;
         cur_y_ff <= pos_y;
         prev_ff  <= buttons;
         if (kind == JOB_PRESS && has_btn) begin
            press_x_ff[btn] <= pos_x;
            press_y_ff[btn] <= pos_y;
            press_b_ff[btn] <= buttons;
         end
      end
   end

endmodule

// ----- sv/pcd_back.sv -----
// ----------------------------------------------------------------------------
// pcd_back
// turns queued jobs into result items, deciding click or drag on release
// ----------------------------------------------------------------------------
module pcd_back
   import pcd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  job_type                   job,
   input  logic                      empty,
   output logic                      pop,
   input  logic [WORD_W-1:0]         click_distance,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [KIND_W-1:0]         rsp_kind,
   output logic signed [COORD_W-1:0] rsp_ax,
   output logic signed [COORD_W-1:0] rsp_ay,
   output logic signed [DELTA_W-1:0] rsp_bx,
   output logic signed [DELTA_W-1:0] rsp_by,
   output logic [WORD_W-1:0]         rsp_wa,
   output logic [WORD_W-1:0]         rsp_wb,
   output logic                      rsp_last
);

   logic                      valid_ff, valid_in;
   logic                      phase_ff, phase_in;
   logic [KIND_W-1:0]         kind_ff, kind_in;
   logic signed [COORD_W-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [DELTA_W-1:0] bx_ff, bx_in, by_ff, by_in;
   logic [WORD_W-1:0]         wa_ff, wa_in, wb_ff, wb_in;
   logic                      last_ff, last_in;

   logic                      out_free, load;
   logic signed [DELTA_W-1:0] rdx, rdy, lim_pos, lim_neg;
   logic                      is_click;

   always_comb begin
      rdx      = {job.x[COORD_W-1], job.x} - {job.px[COORD_W-1], job.px};
      rdy      = {job.y[COORD_W-1], job.y} - {job.py[COORD_W-1], job.py};
      lim_pos  = {1'b0, click_distance};
      lim_neg  = -lim_pos;
      is_click = (rdx < lim_pos) && (rdx > lim_neg) && (rdy < lim_pos) && (rdy > lim_neg);
   end

   always_comb begin
      out_free = !valid_ff || rsp_ready;
      load     = out_free && !empty;
      pop      = 1'b0;
      phase_in = phase_ff;
      valid_in = valid_ff && !rsp_ready;
      kind_in  = kind_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      bx_in    = bx_ff;
      by_in    = by_ff;
      wa_in    = wa_ff;
      wb_in    = wb_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         ax_in    = job.x;
         ay_in    = job.y;
         bx_in    = '0;
         by_in    = '0;
         wa_in    = job.now;
         wb_in    = '0;
         last_in  = 1'b1;
         if (phase_ff) begin
            pop      = 1'b1;
            phase_in = 1'b0;
            if (is_click) begin
               kind_in = EV_CLICKED;
               wa_in   = job.pb;
               wb_in   = job.now;
            end else begin
               kind_in = EV_DRAGGED;
               ax_in   = job.px;
               ay_in   = job.py;
               bx_in   = {job.x[COORD_W-1], job.x};
               by_in   = {job.y[COORD_W-1], job.y};
               wa_in   = job.pb ^ job.now;
            end
         end else begin
            unique case (job.kind)
               JOB_MOVE: begin
                  kind_in = EV_MOVED;
                  bx_in   = job.dx;
                  by_in   = job.dy;
                  pop     = 1'b1;
               end
               JOB_PRESS: begin
                  kind_in = EV_PRESSED;
                  wb_in   = job.diff;
                  pop     = 1'b1;
               end
               JOB_RELEASE: begin
                  kind_in  = EV_RELEASED;
                  wb_in    = job.diff;
                  last_in  = !job.has_btn;
                  pop      = !job.has_btn;
                  phase_in = job.has_btn;
               end
               default: begin
                  kind_in = EV_MOVED;
                  pop     = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      bx_ff   <= bx_in;
      by_ff   <= by_in;
      wa_ff   <= wa_in;
      wb_ff   <= wb_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind  = kind_ff;
   assign rsp_ax    = ax_ff;
   assign rsp_ay    = ay_ff;
   assign rsp_bx    = bx_ff;
   assign rsp_by    = by_ff;
   assign rsp_wa    = wa_ff;
   assign rsp_wb    = wb_ff;
   assign rsp_last  = last_ff;

endmodule

// ----- sv/pcd_checker.sv -----
// ----------------------------------------------------------------------------
// pcd_checker
// port-level checks on the result stream of the classifier
// ----------------------------------------------------------------------------
`include "pointer_click_drag_classifier_defines.svh"

module pcd_checker
   import pcd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [103:0]      rsp_tdata,
   input  logic [KIND_W-1:0] rsp_tuser,
   input  logic              rsp_tlast
);

   `PCD_ASSERT_NEXT(rsp_hold_chk, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
   `PCD_ASSERT_NOW(single_last_chk, clock, reset,
      rsp_tvalid && (rsp_tuser == EV_MOVED || rsp_tuser == EV_PRESSED ||
      rsp_tuser == EV_CLICKED || rsp_tuser == EV_DRAGGED), rsp_tlast)
   `PCD_ASSERT_NOW(release_last_chk, clock, reset,
      rsp_tvalid && !rsp_tlast, rsp_tuser == EV_RELEASED)
   `PCD_ASSERT_NEXT(second_follows_chk, clock, reset,
      rsp_tvalid && rsp_tready && !rsp_tlast,
      rsp_tvalid && (rsp_tuser == EV_CLICKED || rsp_tuser == EV_DRAGGED))
   `PCD_ASSERT_NOW(zero_b_chk, clock, reset,
      rsp_tvalid && (rsp_tuser == EV_PRESSED || rsp_tuser == EV_RELEASED ||
      rsp_tuser == EV_CLICKED), rsp_tdata[65:32] == '0)

endmodule

bind pointer_click_drag_classifier pcd_checker u_pcd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ----- tb/pointer_click_drag_classifier_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pointer_click_drag_classifier_test
// self-checking bench for the pointer click and drag classifier
//
// a directed table walks the first sample, coordinate and button word
// extremes, mixed press and release, changes above the button bits, releases
// of buttons never pressed and the zero and widest click distances. random
// press, move and release sequences with some noise follow under several
// register settings and idle patterns, with one long output stall. every
// event is checked field by field against a bench predictor or a typed row.
// ----------------------------------------------------------------------------
module pointer_click_drag_classifier_test;
   import pcd_pkg::*;

   localparam int BUTTON_COUNT = 5;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [COORD_W-1:0] ax;
      logic [COORD_W-1:0] ay;
      logic [DELTA_W-1:0] bx;
      logic [DELTA_W-1:0] by;
      logic [WORD_W-1:0]  wa;
      logic [WORD_W-1:0]  wb;
      logic               last;
   } pointer_event_type;

   typedef enum bit {ROW_SAMPLE, ROW_CONFIG} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [15:0]       x;
      logic [15:0]       y;
      logic [15:0]       w;
      logic [15:0]       click_dist;
      logic [15:0]       mask;
      bit                typed;
      pointer_event_type ev;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [47:0]            req_tdata = '0;  // pos_x, pos_y, buttons
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [103:0]           rsp_tdata;       // coord_a_x, coord_a_y, coord_b_x,
                                            // coord_b_y, word_a, word_b, zero pad
   logic [KIND_W-1:0]      rsp_tuser;       // event_kind
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_CLICK_DISTANCE;
   logic [WORD_W-1:0]      csr_data = '0;

   pointer_click_drag_classifier #(
      .NUM_BUTTONS(BUTTON_COUNT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // predictor state and register copies
   bit             have_sample = 1'b0;
   int             cur_x = 0;
   int             cur_y = 0;
   logic [15:0]    prev_word = '0;
   int             press_x [BUTTON_COUNT];
   int             press_y [BUTTON_COUNT];
   logic [15:0]    press_word [BUTTON_COUNT];
   logic [15:0]    cfg_click_dist = CLICK_DISTANCE_RESET;
   logic [15:0]    cfg_button_mask = BUTTON_MASK_RESET;

   pointer_event_type step_events [$];
   pointer_event_type expected_events [$];
   stim_row_type      dir_rows [$];

   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   logic           rsp_hold = 1'b0;
   int             mismatch_count = 0;
   int             samples_sent = 0;
   int             events_seen = 0;
   int             settings_used = 0;
   int             kind_count [5];
   int             idle_cycles = 0;
   pointer_event_type want_ev;

   logic signed [15:0] gen_x = '0;
   logic signed [15:0] gen_y = '0;
   logic [15:0]        gen_word = '0;

   function automatic pointer_event_type make_event(logic [KIND_W-1:0] kind, int ax, int ay,
                                                    int bx, int by, logic [15:0] wa,
                                                    logic [15:0] wb);
      pointer_event_type ev;
      ev.kind = kind;
      ev.ax   = ax[15:0];
      ev.ay   = ay[15:0];
      ev.bx   = bx[16:0];
      ev.by   = by[16:0];
      ev.wa   = wa;
      ev.wb   = wb;
      ev.last = 1'b0;
      return ev;
   endfunction

   function automatic stim_row_type sample_row(logic [15:0] x, logic [15:0] y, logic [15:0] w);
      stim_row_type row;
      row.kind       = ROW_SAMPLE;
      row.x          = x;
      row.y          = y;
      row.w          = w;
      row.click_dist = '0;
      row.mask       = '0;
      row.typed      = 1'b0;
      row.ev         = '0;
      return row;
   endfunction

   function automatic stim_row_type typed_row(logic [15:0] x, logic [15:0] y, logic [15:0] w,
                                              pointer_event_type ev);
      stim_row_type row;
      row         = sample_row(x, y, w);
      row.typed   = 1'b1;
      row.ev      = ev;
      row.ev.last = 1'b1;
      return row;
   endfunction

   function automatic stim_row_type csr_row(logic [15:0] click_dist, logic [15:0] mask);
      stim_row_type row;
      row            = sample_row('0, '0, '0);
      row.kind       = ROW_CONFIG;
      row.click_dist = click_dist;
      row.mask       = mask;
      return row;
   endfunction

   // works out the events that one sample causes
   task automatic classify_sample(logic signed [15:0] x, logic signed [15:0] y,
                                  logic [15:0] w);
      int          nx;
      int          ny;
      int          old_x;
      int          old_y;
      int          dx;
      int          dy;
      int          d;
      int          b;
      logic [15:0] diff;
      logic [15:0] change;
      step_events.delete();
      nx = int'(x);
      ny = int'(y);
      if (!have_sample) begin
         prev_word   = '0;
         cur_x       = nx;
         cur_y       = ny;
         have_sample = 1'b1;
      end
      old_x     = cur_x;
      old_y     = cur_y;
      cur_x     = nx;
      cur_y     = ny;
      diff      = prev_word ^ w;
      prev_word = w;
      change    = diff & cfg_button_mask;
      b = -1;
      for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
         if (change[i]) b = i;
      end
      if (change == '0) begin
         step_events.push_back(make_event(EV_MOVED, nx, ny, nx - old_x, ny - old_y, w, '0));
      end else if ((w & change) != '0) begin
         if (b >= 0) begin
            press_x[b]    = nx;
            press_y[b]    = ny;
            press_word[b] = w;
         end
         step_events.push_back(make_event(EV_PRESSED, nx, ny, 0, 0, w, diff));
      end else begin
         step_events.push_back(make_event(EV_RELEASED, nx, ny, 0, 0, w, diff));
         if (b >= 0) begin
            dx = nx - press_x[b];
            dy = ny - press_y[b];
            d  = int'(cfg_click_dist);
            if (dx < d && dx > -d && dy < d && dy > -d)
               step_events.push_back(make_event(EV_CLICKED, nx, ny, 0, 0, press_word[b], w));
            else
               step_events.push_back(make_event(EV_DRAGGED, press_x[b], press_y[b], nx, ny,
                                                press_word[b] ^ w, '0));
         end
      end
      step_events[$].last = 1'b1;
   endtask

   task automatic offer_sample(logic [15:0] x, logic [15:0] y, logic [15:0] w);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {w, y, x};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      samples_sent++;
      classify_sample(x, y, w);
   endtask

   task automatic set_registers(logic [15:0] click_dist, logic [15:0] mask);
      csr_index <= CSR_CLICK_DISTANCE;
      csr_data  <= click_dist;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      cfg_click_dist = click_dist;
      csr_index <= CSR_BUTTON_MASK;
      csr_data  <= mask;
      do @(posedge clock); while (csr_ready !== 1'b1);
      cfg_button_mask = mask;
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic wait_drained(int tail);
      while (expected_events.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic run_phase(logic [15:0] click_dist, logic [15:0] mask, int send_pct,
                            int recv_pct, int count, bit pressure);
      int r;
      int i;
      int travel;
      req_tvalid <= 1'b0;
      wait_drained(4);
      set_registers(click_dist, mask);
      send_idle_pct = send_pct;
      recv_stall_pct <= recv_pct;
      if (pressure) begin
         fork
            begin
               rsp_hold <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
               rsp_hold <= 1'b0;
            end
         join_none
      end
      repeat (count) begin
         r = $urandom_range(99);
         travel = int'($urandom_range(4)) - 2;
         if (r < 8) begin
            gen_x    = 16'($urandom);
            gen_y    = 16'($urandom);
            gen_word = 16'($urandom);
         end else if (r < 45) begin
            if ($urandom_range(15) == 0) begin
               gen_x = $urandom_range(1) ? 16'h7FFF : 16'h8000;
               gen_y = 16'($urandom);
            end else begin
               gen_x = 16'(gen_x + travel);
               gen_y = 16'(gen_y + int'($urandom_range(4)) - 2);
            end
            if ($urandom_range(7) == 0) gen_word = gen_word ^ (16'd1 << $urandom_range(15, 5));
         end else if (r < 72 || gen_word[4:0] == '0) begin
            i = $urandom_range(4);
            gen_word[i] = 1'b1;
            if ($urandom_range(3) == 0) gen_word[15:5] = 11'($urandom);
            gen_x = 16'(gen_x + travel);
         end else begin
            if ($urandom_range(7) == 0) begin
               gen_word[4:0] = '0;
            end else begin
               do i = $urandom_range(4); while (!gen_word[i]);
               gen_word[i] = 1'b0;
            end
            gen_x = 16'(gen_x + travel);
            gen_y = 16'(gen_y + int'($urandom_range(4)) - 2);
         end
         offer_sample(gen_x, gen_y, gen_word);
         foreach (step_events[k]) expected_events.push_back(step_events[k]);
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic check_field(string name, logic [16:0] want, logic [16:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         events_seen++;
         if (rsp_tuser < 5) kind_count[rsp_tuser]++;
         if (expected_events.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected item, expected none, got kind %0d data %h",
                     $time, rsp_tuser, rsp_tdata);
         end else begin
            want_ev = expected_events.pop_front();
            check_field("event_kind", 17'(want_ev.kind), 17'(rsp_tuser));
            check_field("coord_a_x", 17'(want_ev.ax), 17'(rsp_tdata[15:0]));
            check_field("coord_a_y", 17'(want_ev.ay), 17'(rsp_tdata[31:16]));
            check_field("coord_b_x", want_ev.bx, rsp_tdata[48:32]);
            check_field("coord_b_y", want_ev.by, rsp_tdata[65:49]);
            check_field("word_a", 17'(want_ev.wa), 17'(rsp_tdata[81:66]));
            check_field("word_b", 17'(want_ev.wb), 17'(rsp_tdata[97:82]));
            check_field("last_of_run", 17'(want_ev.last), 17'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d items outstanding",
                  $time, STALL_LIMIT, expected_events.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      foreach (press_x[i]) begin
         press_x[i]    = 0;
         press_y[i]    = 0;
         press_word[i] = '0;
      end
      foreach (kind_count[i]) kind_count[i] = 0;

      dir_rows.push_back(typed_row(16'h8000, 16'h7FFF, 16'h0000,
                                   make_event(EV_MOVED, -32768, 32767, 0, 0, '0, '0)));
      dir_rows.push_back(typed_row(16'h7FFF, 16'h8000, 16'h0000,
                                   make_event(EV_MOVED, 32767, -32768, 65535, -65535, '0, '0)));
      dir_rows.push_back(typed_row(16'h7FFF, 16'h8000, 16'hFFFF,
                                   make_event(EV_PRESSED, 32767, -32768, 0, 0,
                                              16'hFFFF, 16'hFFFF)));
      dir_rows.push_back(sample_row(16'h8000, 16'h7FFF, 16'hFFE0));
      // modifier bits drop with no button change
      dir_rows.push_back(sample_row(16'h0000, 16'h0000, 16'h0000));
      dir_rows.push_back(sample_row(16'd5, 16'd5, 16'h0002));
      dir_rows.push_back(sample_row(16'd6, 16'd4, 16'h0002));
      dir_rows.push_back(sample_row(16'd6, 16'd6, 16'h0000));
      dir_rows.push_back(sample_row(16'd10, 16'd10, 16'h0004));
      dir_rows.push_back(sample_row(16'd12, 16'd10, 16'h0000));
      // mixed press and release, then release of a button never pressed
      dir_rows.push_back(sample_row(16'd20, 16'd20, 16'h0008));
      dir_rows.push_back(sample_row(16'd21, 16'd20, 16'h0010));
      dir_rows.push_back(sample_row(16'd22, 16'd20, 16'h0000));
      dir_rows.push_back(sample_row(16'd0, 16'd0, 16'h0003));
      dir_rows.push_back(sample_row(16'd0, 16'd0, 16'h0000));
      // change above the button bits, zero click distance
      dir_rows.push_back(csr_row(16'd0, 16'hFFFF));
      dir_rows.push_back(sample_row(16'd0, 16'd0, 16'h8000));
      dir_rows.push_back(typed_row(16'd0, 16'd0, 16'h0000,
                                   make_event(EV_RELEASED, 0, 0, 0, 0, '0, 16'h8000)));
      dir_rows.push_back(sample_row(16'd3, 16'd3, 16'h0001));
      dir_rows.push_back(sample_row(16'd3, 16'd3, 16'h0000));
      dir_rows.push_back(csr_row(16'hFFFF, 16'h0000));
      dir_rows.push_back(sample_row(16'd100, 16'hFF9C, 16'hFFFF));
      // widest click distance against full-scale travel
      dir_rows.push_back(csr_row(16'hFFFF, 16'h001F));
      dir_rows.push_back(sample_row(16'h8000, 16'h8000, 16'h0001));
      dir_rows.push_back(sample_row(16'h7FFF, 16'h7FFF, 16'h0000));
      dir_rows.push_back(sample_row(16'h7FFF, 16'h7FFF, 16'h0001));
      dir_rows.push_back(sample_row(16'h8001, 16'h8001, 16'h0000));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CONFIG) begin
            req_tvalid <= 1'b0;
            wait_drained(4);
            set_registers(dir_rows[i].click_dist, dir_rows[i].mask);
         end else begin
            offer_sample(dir_rows[i].x, dir_rows[i].y, dir_rows[i].w);
            if (dir_rows[i].typed)
               expected_events.push_back(dir_rows[i].ev);
            else
               foreach (step_events[k]) expected_events.push_back(step_events[k]);
         end
      end

      gen_word = prev_word;
      run_phase(16'd2, 16'h001F, 0, 0, 120, 1'b0);
      run_phase(16'd0, 16'h001F, 84, 0, 120, 1'b0);
      run_phase(16'd1, 16'hFFFF, 0, 84, 120, 1'b0);
      run_phase(16'hFFFF, 16'h001F, 22, 22, 120, 1'b0);
      run_phase(16'($urandom_range(8)), 16'($urandom), 0, 0, 120, 1'b1);
      run_phase(16'd2, 16'h0000, 22, 22, 60, 1'b0);
      run_phase(16'($urandom_range(65535)), 16'(16'h001F | $urandom), 0, 84, 120, 1'b0);
      run_phase(16'd3, 16'h001F, 84, 0, 120, 1'b0);

      wait_drained(20);
      $display("covered %0d samples giving %0d events: moved %0d, pressed %0d, released %0d",
               samples_sent, events_seen, kind_count[0], kind_count[1], kind_count[2]);
      $display("clicked %0d, dragged %0d, over %0d register settings and four idle patterns",
               kind_count[3], kind_count[4], settings_used);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/pcd_pkg.sv
sv/pcd_queue.sv
sv/pcd_front.sv
sv/pcd_back.sv
sv/pointer_click_drag_classifier.sv
sv/pcd_checker.sv
tb/pointer_click_drag_classifier_test.sv
